@@ sv/ltbm_pkg.sv @@
// ----------------------------------------------------------------------------
// ltbm_pkg
// Shared types and constants for the log time bin merger.
// ----------------------------------------------------------------------------
package ltbm_pkg;

  localparam int BIN_SLOTS = 32;
  localparam int SLOT_W    = $clog2(BIN_SLOTS);
  localparam int IDX_W     = 6;
  localparam int WID_W     = 20;
  localparam int TIME_W    = 32;
  localparam int MC_W      = 4;
  localparam int QDEPTH    = 2;

  localparam logic [WID_W-1:0] WIDTH_CAP = 20'h80000;

  typedef enum logic {
    CMD_CLEAR = 1'b0,
    CMD_ADD   = 1'b1
  } cmd_t;

  typedef enum logic {
    CFG_MERGE_COUNT = 1'b0,
    CFG_ORIGIN_TIME = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic              add;
    logic [TIME_W-1:0] t;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_SCAN,
    ST_MERGE,
    ST_SHIFT,
    ST_EMIT
  } state_t;

endpackage

@@ sv/log_time_bin_merger_core.sv @@
// ----------------------------------------------------------------------------
// log_time_bin_merger_core
// Logarithmic time-bin layout with pairwise merging of equal-width runs.
// ----------------------------------------------------------------------------
// Channel | Dir | tdata                                    | tuser    | tlast
// in      | in  | step_time[31:0]                          | cmd      | -
// out     | out | idx[5:0] width[25:6] edge[57:26] dur[89:58] | overflow | last_bin
// cfg     | in  | index 0 merge_count, 1 origin_time       | -        | -
//
// An add takes the item, loads the scan width (not on the first add), scans the
// bins for each width tried, merges and shifts each run found, then emits all
// active bins; an add into a full layout emits with overflow; clear empties all.
// The bin engine handles one item at a time; a 2-entry queue keeps input open.
// Reset (synchronous, rst_n low) empties the layout and restores the state and config registers.
// ----------------------------------------------------------------------------
module log_time_bin_merger_core
  import ltbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // step_time
  input  logic              in_tuser,   // cmd
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [95:0]       out_tdata,  // bin_index, bin_width, bin_edge, bin_duration, pad
  output logic              out_tlast,
  output logic              out_tuser,  // overflow
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [31:0]       cfg_wdata
);

  logic job_valid, job_take;
  job_t job;

  ltbm_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .job_valid, .job_take, .job
  );

  ltbm_back u_back (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata,
    .job_valid, .job_take, .job,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser
  );

endmodule

@@ sv/ltbm_front.sv @@
// ----------------------------------------------------------------------------
// ltbm_front
// Input stage: accepts commands and queues them for the bin engine.
// ----------------------------------------------------------------------------
module ltbm_front
  import ltbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [TIME_W-1:0] in_tdata,
  input  logic              in_tuser,
  output logic              job_valid,
  input  logic              job_take,
  output job_t              job
);

  job_t      q_r [QDEPTH];
  logic      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic      push, pop;

  assign in_tready = (cnt_r != 2'(QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign job_valid = (cnt_r != 2'd0);
  assign pop       = job_valid && job_take;
  assign job       = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r].add <= (in_tuser == CMD_ADD);
      q_r[wp_r].t   <= in_tdata;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(QDEPTH)) else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(QDEPTH)) |-> !push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !pop) else $error("pop from empty queue");

endmodule

@@ sv/ltbm_back.sv @@
// ----------------------------------------------------------------------------
// ltbm_back
// Bin engine: appends, scans for runs, merges with a one-slot-per-cycle
// shift, then streams the active bins out.
// ----------------------------------------------------------------------------
module ltbm_back
  import ltbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [TIME_W-1:0] cfg_wdata,
  input  logic              job_valid,
  output logic              job_take,
  input  job_t              job,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [95:0]       out_tdata,
  output logic              out_tlast,
  output logic              out_tuser
);

  logic [WID_W-1:0]  wid_r [BIN_SLOTS];
  logic [TIME_W-1:0] edg_r [BIN_SLOTS];
  logic [SLOT_W-1:0] top_r, top_nxt;
  logic              empty_r, empty_nxt;
  logic [MC_W-1:0]   mc_r;
  logic [TIME_W-1:0] org_r;
  state_t            st_r, st_nxt;
  logic [SLOT_W:0]   i_r, i_nxt;
  logic [WID_W-1:0]  dt_r, dt_nxt;
  logic [SLOT_W:0]   n_r, n_nxt;
  logic [SLOT_W-1:0] at_r, at_nxt;
  logic              ovf_r, ovf_nxt;
  logic              ov_r, ov_nxt;
  logic [IDX_W-1:0]  o_idx_r, o_idx_nxt;
  logic [WID_W-1:0]  o_wid_r, o_wid_nxt;
  logic [TIME_W-1:0] o_edg_r, o_edg_nxt, o_dur_r, o_dur_nxt;
  logic              o_last_r, o_last_nxt, o_ovf_r, o_ovf_nxt;
  logic [MC_W-1:0]   need;
  logic [SLOT_W-1:0] ii;
  logic              in_run, run_merge;

  // one write per cycle into the table, or a clear of every slot
  logic              tw_en, tw_clr;
  logic [SLOT_W-1:0] tw_a;
  logic [WID_W-1:0]  tw_w;
  logic [TIME_W-1:0] tw_e;

  assign need  = (mc_r < MC_W'(2)) ? MC_W'(2) : mc_r;
  assign ii    = i_r[SLOT_W-1:0];
  assign in_run = (i_r <= {1'b0, top_r}) && (wid_r[ii] == dt_r);
  assign run_merge = !((n_r < (SLOT_W+1)'(need)) ||
                       ((n_r == (SLOT_W+1)'(need)) && (dt_r == WID_W'(1))) ||
                       (dt_r >= WIDTH_CAP));

  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, o_dur_r, o_edg_r, o_wid_r, o_idx_r};
  assign out_tlast  = o_last_r;
  assign out_tuser  = o_ovf_r;

  always_comb begin
    st_nxt = st_r; i_nxt = i_r; dt_nxt = dt_r; n_nxt = n_r; at_nxt = at_r;
    ovf_nxt = ovf_r; top_nxt = top_r; empty_nxt = empty_r; ov_nxt = ov_r;
    o_idx_nxt = o_idx_r; o_wid_nxt = o_wid_r; o_edg_nxt = o_edg_r;
    o_dur_nxt = o_dur_r; o_last_nxt = o_last_r; o_ovf_nxt = o_ovf_r;
    job_take = 1'b0;
    tw_en = 1'b0; tw_clr = 1'b0; tw_a = '0; tw_w = '0; tw_e = '0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_take = 1'b1;
          if (!job.add) begin
            tw_clr    = 1'b1;
            top_nxt   = '0;
            empty_nxt = 1'b1;
          end else begin
            ovf_nxt = 1'b0;
            st_nxt  = ST_SCAN;
            i_nxt   = '0;
            n_nxt   = '0;
            if (empty_r) begin
              tw_en = 1'b1; tw_a = '0; tw_w = WID_W'(1); tw_e = job.t;
              top_nxt = '0; empty_nxt = 1'b0;
              dt_nxt  = WID_W'(1);
            end else if (top_r == SLOT_W'(BIN_SLOTS - 1)) begin
              ovf_nxt = 1'b1;
              st_nxt  = ST_EMIT;
            end else begin
              tw_en = 1'b1; tw_a = top_r + SLOT_W'(1); tw_w = WID_W'(1);
              tw_e = job.t; top_nxt = top_r + SLOT_W'(1);
              st_nxt = ST_APPEND;
            end
          end
        end
      end
      ST_APPEND: begin
        dt_nxt = wid_r[0];
        st_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (dt_r == '0) begin
          st_nxt = ST_EMIT;
          i_nxt  = '0;
        end else if (in_run) begin
          i_nxt = i_r + 1'b1;
          n_nxt = n_r + 1'b1;
        end else if (run_merge) begin
          at_nxt = SLOT_W'(i_r - n_r);
          st_nxt = ST_MERGE;
        end else begin
          dt_nxt = dt_r >> 1;
          n_nxt  = '0;
        end
      end
      ST_MERGE: begin
        tw_en = 1'b1; tw_a = at_r; tw_w = wid_r[at_r] << 1;
        tw_e  = edg_r[at_r + SLOT_W'(1)];
        at_nxt = at_r + SLOT_W'(1);
        st_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        tw_en = 1'b1; tw_a = at_r;
        if (at_r < top_r) begin
          tw_w = wid_r[at_r + SLOT_W'(1)];
          tw_e = edg_r[at_r + SLOT_W'(1)];
          at_nxt = at_r + SLOT_W'(1);
        end else begin
          top_nxt = top_r - SLOT_W'(1);
          st_nxt  = ST_APPEND;
          i_nxt   = '0;
          n_nxt   = '0;
        end
      end
      ST_EMIT: begin
        if (!ov_r || out_tready) begin
          ov_nxt     = 1'b1;
          o_idx_nxt  = IDX_W'(i_r);
          o_wid_nxt  = wid_r[ii];
          o_edg_nxt  = edg_r[ii];
          o_dur_nxt  = ((ii == '0) ? org_r : edg_r[ii - SLOT_W'(1)]) - edg_r[ii];
          o_last_nxt = (ii == top_r);
          o_ovf_nxt  = ovf_r;
          i_nxt      = i_r + 1'b1;
          if (ii == top_r) st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; top_r <= '0; empty_r <= 1'b1; ov_r <= 1'b0;
      mc_r <= MC_W'(3); org_r <= '0;
      for (int k = 0; k < BIN_SLOTS; k++) begin
        wid_r[k] <= '0;
        edg_r[k] <= '0;
      end
    end else begin
      st_r <= st_nxt; top_r <= top_nxt; empty_r <= empty_nxt; ov_r <= ov_nxt;
      if (cfg_we && cfg_addr == CFG_MERGE_COUNT) mc_r <= cfg_wdata[MC_W-1:0];
      if (cfg_we && cfg_addr == CFG_ORIGIN_TIME) org_r <= cfg_wdata;
      if (tw_clr) begin
        for (int k = 0; k < BIN_SLOTS; k++) begin
          wid_r[k] <= '0;
          edg_r[k] <= '0;
        end
      end else if (tw_en) begin
        wid_r[tw_a] <= tw_w;
        edg_r[tw_a] <= tw_e;
      end
    end
    i_r <= i_nxt; dt_r <= dt_nxt; n_r <= n_nxt; at_r <= at_nxt; ovf_r <= ovf_nxt;
    o_idx_r <= o_idx_nxt; o_wid_r <= o_wid_nxt; o_edg_r <= o_edg_nxt;
    o_dur_r <= o_dur_nxt; o_last_r <= o_last_nxt; o_ovf_r <= o_ovf_nxt;
  end

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |-> (st_r == ST_IDLE)) else $error("job taken while busy");
  a_merge_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MERGE) |=> (st_r == ST_SHIFT)) else $error("merge not followed by shift");
  a_top_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (top_r == '0)) else $error("empty layout with bins");

endmodule
